### sv/binary_max_heap_priority_queue_top_assert.svh
// Assertion macros for the heap priority queue checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define BMHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BMHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bmhpq_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; imported by the top level, the checker and the bench.
package bmhpq_pkg;

  localparam int CAPACITY      = 64;
  localparam int VALUE_BITS    = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int ADDR_BITS     = $clog2(CAPACITY);
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
  localparam int IDX_BITS      = ADDR_BITS + 2;
  localparam int ENTRY_BITS    = VALUE_BITS + PRIORITY_BITS;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    func_e                    func;
    logic [VALUE_BITS-1:0]    entry_value;
    logic [PRIORITY_BITS-1:0] entry_priority;
  } req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    front_value;
    logic [PRIORITY_BITS-1:0] front_priority;
    logic [COUNT_BITS-1:0]    item_count;
    logic                     is_empty;
    status_e                  status;
  } rsp_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] priority_v;
  } entry_t;

endpackage

### sv/binary_max_heap_priority_queue_top.sv
// Binary max-heap priority queue: one request in, one response out per request.
// Depends on bmhpq_pkg and bmhpq_ram.
//
// Requests are handled one at a time against a single slot RAM with one read
// and one write port. A push reads and compares parents (a read and a compare
// each) until a parent's priority is at least as high or the root is reached;
// a pop reads the last entry and sinks it level by level (two child reads and
// a compare per level) until it reaches a leaf or a compare stops it. A
// dropped push or an ignored pop goes straight to the root read and response.
// A response that is still waiting holds the next one in S_RESP. The sift
// moves a hole rather than swapping, so each level costs one RAM write at
// most. The response register lets the next request enter while a response
// still waits.
module binary_max_heap_priority_queue_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bmhpq_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bmhpq_pkg::rsp_t out_rsp_o
);
  import bmhpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_RD_LAST,
    S_POP_LAST,
    S_POP_RD_L,
    S_POP_RD_R,
    S_POP_CMP,
    S_WR_ITEM,
    S_RD_ROOT,
    S_RESP
  } state_e;

  state_e                state_q;
  entry_t                item_q;
  entry_t                left_q;
  logic                  has_right_q;
  logic [ADDR_BITS-1:0]  pos_q;
  logic [COUNT_BITS-1:0] count_q;
  status_e               status_q;
  logic                  out_valid_q;
  rsp_t                  rsp_q;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  entry_t                ram_wdata;
  logic                  ram_re;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;
  entry_t                rd_entry;

  logic [IDX_BITS-1:0]   lc;
  logic [IDX_BITS-1:0]   rc;
  logic [IDX_BITS-1:0]   cnt_ext;
  logic [ADDR_BITS-1:0]  parent;
  logic                  take_right;
  entry_t                big;
  logic [ADDR_BITS-1:0]  big_idx;
  logic                  sink;

  bmhpq_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(ENTRY_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry   = entry_t'(ram_rdata);
  assign lc         = (IDX_BITS'(pos_q) << 1) + IDX_BITS'(1);
  assign rc         = lc + IDX_BITS'(1);
  assign cnt_ext    = IDX_BITS'(count_q);
  assign parent     = (pos_q - ADDR_BITS'(1)) >> 1;
  assign take_right = has_right_q && (left_q.priority_v <= rd_entry.priority_v);
  assign big        = take_right ? rd_entry : left_q;
  assign big_idx    = take_right ? rc[ADDR_BITS-1:0] : lc[ADDR_BITS-1:0];
  assign sink       = item_q.priority_v <= big.priority_v;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = item_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_PUSH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = parent;
      end
      S_PUSH_CMP: begin
        if (rd_entry.priority_v < item_q.priority_v) begin
          ram_we    = 1'b1;
          ram_wdata = rd_entry;
        end
      end
      S_POP_RD_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = count_q[ADDR_BITS-1:0];
      end
      S_POP_RD_L: begin
        if (lc < cnt_ext) begin
          ram_re    = 1'b1;
          ram_raddr = lc[ADDR_BITS-1:0];
        end
      end
      S_POP_RD_R: begin
        if (rc < cnt_ext) begin
          ram_re    = 1'b1;
          ram_raddr = rc[ADDR_BITS-1:0];
        end
      end
      S_POP_CMP: begin
        if (sink) begin
          ram_we    = 1'b1;
          ram_wdata = big;
        end
      end
      S_WR_ITEM: begin
        ram_we = 1'b1;
      end
      S_RD_ROOT: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      left_q      <= '0;
      has_right_q <= 1'b0;
      pos_q       <= '0;
      count_q     <= '0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q.value      <= in_req_i.entry_value;
            item_q.priority_v <= in_req_i.entry_priority;
            status_q          <= STATUS_OK;
            if (in_req_i.func == FUNC_PUSH) begin
              if (count_q == COUNT_BITS'(CAPACITY)) begin
                status_q <= STATUS_DROPPED;
                state_q  <= S_RD_ROOT;
              end else begin
                pos_q   <= count_q[ADDR_BITS-1:0];
                count_q <= count_q + COUNT_BITS'(1);
                state_q <= (count_q == '0) ? S_WR_ITEM : S_PUSH_RD;
              end
            end else begin
              if (count_q == '0) begin
                status_q <= STATUS_IGNORED;
                state_q  <= S_RD_ROOT;
              end else begin
                pos_q   <= '0;
                count_q <= count_q - COUNT_BITS'(1);
                state_q <= S_POP_RD_LAST;
              end
            end
          end
        end
        S_PUSH_RD: begin
          state_q <= S_PUSH_CMP;
        end
        S_PUSH_CMP: begin
          if (rd_entry.priority_v < item_q.priority_v) begin
            pos_q   <= parent;
            state_q <= (parent == '0) ? S_WR_ITEM : S_PUSH_RD;
          end else begin
            state_q <= S_WR_ITEM;
          end
        end
        S_POP_RD_LAST: begin
          state_q <= S_POP_LAST;
        end
        S_POP_LAST: begin
          item_q  <= rd_entry;
          state_q <= S_POP_RD_L;
        end
        S_POP_RD_L: begin
          state_q <= (lc < cnt_ext) ? S_POP_RD_R : S_WR_ITEM;
        end
        S_POP_RD_R: begin
          left_q      <= rd_entry;
          has_right_q <= (rc < cnt_ext);
          state_q     <= S_POP_CMP;
        end
        S_POP_CMP: begin
          if (sink) begin
            pos_q   <= big_idx;
            state_q <= S_POP_RD_L;
          end else begin
            state_q <= S_WR_ITEM;
          end
        end
        S_WR_ITEM: begin
          state_q <= S_RD_ROOT;
        end
        S_RD_ROOT: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            rsp_q.front_value    <= (count_q == '0) ? '0 : rd_entry.value;
            rsp_q.front_priority <= (count_q == '0) ? '0 : rd_entry.priority_v;
            rsp_q.item_count     <= count_q;
            rsp_q.is_empty       <= (count_q == '0);
            rsp_q.status         <= status_q;
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/bmhpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the heap slots.
module bmhpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### sv/bmhpq_checker.sv
// Port-level checker for the heap priority queue, bound to the top level.
// Depends on bmhpq_pkg and binary_max_heap_priority_queue_top_assert.svh.
`include "binary_max_heap_priority_queue_top_assert.svh"

module bmhpq_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input bmhpq_pkg::req_t in_req_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input bmhpq_pkg::rsp_t out_rsp_o
);
  import bmhpq_pkg::*;

  `BMHPQ_ASSERT(a_count_bound, !out_valid_o || (out_rsp_o.item_count <= COUNT_BITS'(CAPACITY)), "item_count above capacity")
  `BMHPQ_ASSERT(a_empty_flag, !out_valid_o || (out_rsp_o.is_empty == (out_rsp_o.item_count == '0)), "is_empty disagrees with item_count")
  `BMHPQ_ASSERT(a_empty_front, !out_valid_o || !out_rsp_o.is_empty || ((out_rsp_o.front_value == '0) && (out_rsp_o.front_priority == '0)), "empty heap shows a front entry")
  `BMHPQ_ASSERT(a_status_code, !out_valid_o || (out_rsp_o.status == STATUS_OK) || (out_rsp_o.status == STATUS_DROPPED) || (out_rsp_o.status == STATUS_IGNORED), "undefined status code")
  `BMHPQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "stalled response dropped or changed")

endmodule

bind binary_max_heap_priority_queue_top bmhpq_checker u_bmhpq_checker (.*);

### bench/binary_max_heap_priority_queue_top_test.sv
// Self-checking bench for binary_max_heap_priority_queue_top: random push/pop
// traffic with idle gaps on both sides, checked against an in-bench heap model.
// Depends on bmhpq_pkg and the block's RTL.
module binary_max_heap_priority_queue_top_test;
  import bmhpq_pkg::*;

  localparam int RANDOM_ITEMS = 1825;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AT_RSP  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic drain;
    req_t req;
  } plan_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  plan_t pending_req[$];
  rsp_t  expected_rsp[$];

  logic [PRIORITY_BITS-1:0] heap_pri[CAPACITY];
  logic [VALUE_BITS-1:0]    heap_val[CAPACITY];
  logic [COUNT_BITS-1:0]    heap_cnt;

  int errors;
  int rsp_seen;
  int idle_cycles;
  bit req_taken;
  bit send_busy;
  bit sink_busy;
  int send_gap;
  int sink_gap;
  int hold_left;
  bit hold_done;

  binary_max_heap_priority_queue_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  function automatic void slot_swap(int a, int b);
    logic [PRIORITY_BITS-1:0] tp;
    logic [VALUE_BITS-1:0]    tv;
    tp = heap_pri[a];
    tv = heap_val[a];
    heap_pri[a] = heap_pri[b];
    heap_val[a] = heap_val[b];
    heap_pri[b] = tp;
    heap_val[b] = tv;
  endfunction

  // Applies one request to the heap copy and returns the response it implies.
  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    int   pos;
    int   lc;
    int   rc;
    int   big;
    bit   sinking;
    o = '0;
    o.status = STATUS_OK;
    if (r.func == FUNC_PUSH) begin
      if (heap_cnt >= CAPACITY) begin
        o.status = STATUS_DROPPED;
      end else begin
        pos = heap_cnt;
        heap_val[pos] = r.entry_value;
        heap_pri[pos] = r.entry_priority;
        heap_cnt = heap_cnt + 1'b1;
        while (pos != 0 && heap_pri[(pos - 1) / 2] < heap_pri[pos]) begin
          slot_swap((pos - 1) / 2, pos);
          pos = (pos - 1) / 2;
        end
      end
    end else begin
      if (heap_cnt == 0) begin
        o.status = STATUS_IGNORED;
      end else begin
        heap_cnt = heap_cnt - 1'b1;
        heap_val[0] = heap_val[heap_cnt];
        heap_pri[0] = heap_pri[heap_cnt];
        pos = 0;
        sinking = 1'b1;
        while (sinking) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          if (lc >= heap_cnt) begin
            sinking = 1'b0;
          end else begin
            big = lc;
            if (rc < heap_cnt) begin
              if (heap_pri[lc] <= heap_pri[rc]) big = rc;
            end
            if (heap_pri[pos] <= heap_pri[big]) begin
              slot_swap(pos, big);
              pos = big;
            end else begin
              sinking = 1'b0;
            end
          end
        end
      end
    end
    if (heap_cnt != 0) begin
      o.front_value    = heap_val[0];
      o.front_priority = heap_pri[0];
    end
    o.item_count = heap_cnt;
    o.is_empty   = (heap_cnt == 0);
    return o;
  endfunction

  function automatic int pick_gap(bit busy);
    int r;
    r = $urandom_range(99);
    if (!busy || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  task automatic add_push(logic [VALUE_BITS-1:0] v, logic [PRIORITY_BITS-1:0] p);
    plan_t s;
    s = '0;
    s.req.func           = FUNC_PUSH;
    s.req.entry_value    = v;
    s.req.entry_priority = p;
    pending_req.push_back(s);
  endtask

  task automatic add_pop();
    plan_t s;
    s = '0;
    s.req.func           = FUNC_POP;
    s.req.entry_value    = $urandom;
    s.req.entry_priority = $urandom;
    pending_req.push_back(s);
  endtask

  task automatic add_drain();
    plan_t s;
    s = '0;
    s.drain = 1'b1;
    pending_req.push_back(s);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Request driver: holds a request until taken, idles at random, and
  // waits for all responses at each drain mark.
  always @(negedge clk_i) begin : drive_proc
    logic  drive;
    req_t  nxt;
    plan_t head;
    drive = in_valid_i && !req_taken;
    nxt   = in_req_i;
    if (!drive && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_req.size() > 0) begin
        head = pending_req[0];
        if (head.drain) begin
          if (expected_rsp.size() == 0) void'(pending_req.pop_front());
        end else begin
          void'(pending_req.pop_front());
          nxt   = head.req;
          drive = 1'b1;
          send_gap = pick_gap(send_busy);
          if ($urandom_range(63) == 0) send_busy = !send_busy;
        end
      end
    end
    in_valid_i <= drive;
    in_req_i   <= nxt;
  end

  // Response sink: random stalls plus one long hold-off mid-run.
  always @(negedge clk_i) begin : sink_proc
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else if (sink_gap > 0) begin
        sink_gap--;
      end else begin
        rdy = 1'b1;
        sink_gap = pick_gap(sink_busy);
        if ($urandom_range(63) == 0) sink_busy = !sink_busy;
      end
    end
    out_ready_i <= rdy;
  end

  // Monitor: predicts on request acceptance, checks on response acceptance.
  always @(posedge clk_i) begin : watch_proc
    rsp_t want;
    if (rst_ni) begin
      req_taken = in_valid_i && in_ready_o;
      if (req_taken) expected_rsp.push_back(heap_apply(in_req_i));
      if (out_valid_o && out_ready_i) begin
        rsp_seen++;
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("%0t unexpected response: expected none actual %0h", $time, out_rsp_o);
        end else begin
          want = expected_rsp.pop_front();
          check_field("front_value", out_rsp_o.front_value, want.front_value);
          check_field("front_priority", out_rsp_o.front_priority, want.front_priority);
          check_field("item_count", out_rsp_o.item_count, want.item_count);
          check_field("is_empty", out_rsp_o.is_empty, want.is_empty);
          check_field("status", out_rsp_o.status, want.status);
        end
      end
      if (req_taken || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin : stim_proc
    int n;
    int k;
    int len;
    int push_pct;
    bit narrow;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    heap_cnt    = '0;
    errors      = 0;
    rsp_seen    = 0;
    idle_cycles = 0;
    req_taken   = 1'b0;
    send_busy   = 1'b1;
    sink_busy   = 1'b1;
    send_gap    = 0;
    sink_gap    = 0;
    hold_left   = 0;
    hold_done   = 1'b0;

    // directed: empty pop, single entry, extremes, ties on push and pop
    add_pop();
    add_push(16'h0000, 16'h0000);
    add_pop();
    add_pop();
    add_push(16'hffff, 16'hffff);
    add_push(16'h0001, 16'hffff);
    add_push(16'haaaa, 16'h0000);
    add_push(16'h5555, 16'hffff);
    add_push(16'hffff, 16'h8000);
    add_push(16'h0000, 16'h7fff);
    add_pop();
    add_pop();
    add_pop();
    add_push(16'h0011, 16'h0005);
    add_push(16'h0022, 16'h0005);
    add_push(16'h0033, 16'h0005);
    add_push(16'h0044, 16'h0005);
    for (k = 0; k < 8; k++) add_pop();
    add_drain();

    // random: fill, drain and mixed phases; the first one fills the heap
    n = 0;
    while (n < RANDOM_ITEMS) begin
      k = (n == 0) ? 0 : $urandom_range(2);
      len = (n == 0) ? 110 : $urandom_range(120, 20);
      if (len > RANDOM_ITEMS - n) len = RANDOM_ITEMS - n;
      narrow = $urandom_range(1);
      case (k)
        0: begin
          push_pct = 90;
        end
        1: begin
          push_pct = 15;
        end
        default: begin
          push_pct = 55;
        end
      endcase
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < push_pct) begin
          add_push($urandom, narrow ? $urandom_range(7) : $urandom);
        end else begin
          add_pop();
        end
      end
      n += len;
      if ($urandom_range(5) == 0) add_drain();
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_req.size() > 0 || in_valid_i || expected_rsp.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
